[hw/rtl/cts_pkg.sv]
// Shared types and constants for the column texture sampler.
package cts_pkg;

	localparam int COORD_BITS = 12;

	// Result kinds
	localparam logic [1:0] KIND_FETCH = 2'd0;
	localparam logic [1:0] KIND_PIXEL = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_SCREEN_WIDTH    = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT   = 2'd1;
	localparam logic [1:0] CFG_LINE_BYTES      = 2'd2;
	localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd3;

	// Input op codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TEXEL = 1'b1;

	localparam logic [31:0] TEXEL_WHITE = 32'hFFFF_FFFF;

	localparam logic [11:0] RST_SCREEN_WIDTH    = 12'd640;
	localparam logic [11:0] RST_SCREEN_HEIGHT   = 12'd480;
	localparam logic [12:0] RST_LINE_BYTES      = 13'd256;
	localparam logic [3:0]  RST_BYTES_PER_PIXEL = 4'd4;

	typedef struct packed {
		logic                  op;
		logic [COORD_BITS-1:0] start_row;
		logic [COORD_BITS-1:0] bottom_row;
		logic [15:0]           column_height;
		logic [5:0]            tex_x;
		logic [COORD_BITS-1:0] screen_x;
		logic                  sprite_mode;
		logic [2:0]            texture_id;
		logic [31:0]           texel;
	} cts_in_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [2:0]            fetch_texture;
		logic [17:0]           fetch_offset;
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [31:0]           color;
		logic                  last;
	} cts_out_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_PIXEL,
		EMIT_FETCH,
		EMIT_DONE
	} cts_emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIXEL,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_OFS,
		ST_FETCH,
		ST_DONE
	} cts_state_t;

	typedef struct packed {
		logic      start;
		logic      take_texel;
		logic      row_inc;
		logic      calc_d;
		logic      load_div;
		logic      div_step;
		logic      calc_ofs;
		logic      clear_busy;
		cts_emit_t emit;
	} cts_cmd_t;

	typedef struct packed {
		logic op;
		logic busy;
		logic skip;
		logic row_ok;
		logic d_neg;
		logic d_ge_h;
		logic div_last;
		logic out_free;
	} cts_sts_t;

endpackage

[hw/rtl/cts_ctrl.sv]
// Sequencer for the column texture sampler: one item at a time through check, divide and emit.
module cts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_accept,
	input  cts_pkg::cts_sts_t sts,
	output logic              item_stall,
	output cts_pkg::cts_cmd_t cmd,
	output cts_pkg::cts_state_t state
);
	import cts_pkg::*;

	cts_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_accept) begin
					if (sts.op == OP_START) begin
						state_nxt = ST_CHECK;
					end else if (sts.busy) begin
						state_nxt = sts.skip ? ST_CHECK : ST_PIXEL;
					end
				end
			end
			ST_PIXEL: begin
				if (sts.out_free) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_nxt = sts.row_ok ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				// out-of-range rows clamp and bypass the divider
				state_nxt = (sts.d_neg || sts.d_ge_h) ? ST_OFS : ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_nxt = ST_OFS;
				end
			end
			ST_OFS: begin
				state_nxt = ST_FETCH;
			end
			ST_FETCH: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// input is taken only while idle
	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.emit   = EMIT_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (item_accept) begin
					if (sts.op == OP_START) begin
						cmd.start = 1'b1;
					end else if (sts.busy) begin
						cmd.take_texel = 1'b1;
						cmd.row_inc    = sts.skip;
					end
				end
			end
			ST_PIXEL: begin
				if (sts.out_free) begin
					cmd.emit    = EMIT_PIXEL;
					cmd.row_inc = 1'b1;
				end
			end
			ST_CHECK: begin
				cmd.calc_d = 1'b1;
			end
			ST_MUL: begin
				cmd.load_div = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_OFS: begin
				cmd.calc_ofs = 1'b1;
			end
			ST_FETCH: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_FETCH;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit       = EMIT_DONE;
					cmd.clear_busy = 1'b1;
				end
			end
			default: begin
				cmd.emit = EMIT_NONE;
			end
		endcase
	end

	assign state = state_q;

endmodule

[hw/rtl/cts_dp.sv]
// Datapath of the column texture sampler: column registers, divider, offset and result register.
module cts_dp #(
	parameter int TEX_SIZE = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cts_pkg::cts_in_t    item_data,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [12:0]         cfg_data,
	input  cts_pkg::cts_cmd_t   cmd,
	input  logic                result_stall,
	output cts_pkg::cts_sts_t   sts,
	output logic                result_valid,
	output cts_pkg::cts_out_t   result_data
);
	import cts_pkg::*;

	localparam int QB    = $clog2(TEX_SIZE);
	localparam int CW    = $clog2(QB);
	localparam int NUM_W = 16 + QB;

	logic [11:0] screen_width_q, screen_height_q;
	logic [12:0] line_bytes_q;
	logic [3:0]  bytes_per_pixel_q;

	logic                  busy_q;
	logic [COORD_BITS-1:0] row_q, stop_q, screen_x_q;
	logic [15:0]           height_q;
	logic [5:0]            tex_x_q;
	logic                  sprite_q;
	logic [2:0]            texture_q;
	logic [31:0]           texel_q;

	logic signed [17:0] d_q;
	logic [NUM_W-1:0]   rem_q, dv_q, num;
	logic [QB-1:0]      quo_q;
	logic [CW-1:0]      cnt_q;
	logic [17:0]        off_q;

	logic     out_valid_q;
	cts_out_t out_q;
	cts_out_t out_nxt;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q    <= RST_SCREEN_WIDTH;
			screen_height_q   <= RST_SCREEN_HEIGHT;
			line_bytes_q      <= RST_LINE_BYTES;
			bytes_per_pixel_q <= RST_BYTES_PER_PIXEL;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:    screen_width_q    <= cfg_data[11:0];
				CFG_SCREEN_HEIGHT:   screen_height_q   <= cfg_data[11:0];
				CFG_LINE_BYTES:      line_bytes_q      <= cfg_data;
				CFG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_data[3:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
		end else if (cmd.clear_busy) begin
			busy_q <= 1'b0;
		end
	end

	// column registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_q      <= item_data.start_row;
			stop_q     <= item_data.bottom_row;
			height_q   <= (item_data.column_height == 16'd0) ? 16'd1 : item_data.column_height;
			tex_x_q    <= item_data.tex_x;
			screen_x_q <= item_data.screen_x;
			sprite_q   <= item_data.sprite_mode;
			texture_q  <= item_data.texture_id;
		end else if (cmd.row_inc) begin
			row_q <= row_q + 1'b1;
		end
		if (cmd.take_texel) begin
			texel_q <= item_data.texel;
		end
	end

	// d = row + h/2 - screen_height/2; its sign and size against h decide the clamp
	assign num = NUM_W'(d_q[15:0]) * NUM_W'(TEX_SIZE);

	always_ff @(posedge clk) begin
		if (cmd.calc_d) begin
			d_q <= $signed({6'd0, row_q}) + $signed({3'd0, height_q[15:1]})
				- $signed({7'd0, screen_height_q[11:1]});
		end
		if (cmd.load_div) begin
			rem_q <= num;
			dv_q  <= NUM_W'(height_q) << (QB - 1);
			cnt_q <= CW'(QB - 1);
			quo_q <= (!sts.d_neg && sts.d_ge_h) ? QB'(TEX_SIZE - 1) : '0;
		end else if (cmd.div_step) begin
			// restoring division, one quotient bit a cycle
			if (rem_q >= dv_q) begin
				rem_q <= rem_q - dv_q;
				quo_q <= {quo_q[QB-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QB-2:0], 1'b0};
			end
			dv_q  <= dv_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.calc_ofs) begin
			off_q <= 18'(quo_q) * 18'(line_bytes_q) + 18'(tex_x_q) * 18'(bytes_per_pixel_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// fields with no meaning for the kind stay zero
	always_comb begin
		out_nxt = '0;
		unique case (cmd.emit)
			EMIT_PIXEL: begin
				out_nxt.kind    = KIND_PIXEL;
				out_nxt.pixel_x = screen_x_q;
				out_nxt.pixel_y = row_q;
				out_nxt.color   = texel_q;
			end
			EMIT_FETCH: begin
				out_nxt.kind          = KIND_FETCH;
				out_nxt.fetch_texture = texture_q;
				out_nxt.fetch_offset  = off_q;
				out_nxt.last          = 1'b1;
			end
			EMIT_DONE: begin
				out_nxt.kind = KIND_DONE;
				out_nxt.last = 1'b1;
			end
			EMIT_NONE: begin
				out_nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EMIT_NONE) begin
			out_q <= out_nxt;
		end
	end

	always_comb begin
		sts.op       = item_data.op;
		sts.busy     = busy_q;
		sts.skip     = sprite_q && (item_data.texel == '0 || item_data.texel == TEXEL_WHITE);
		sts.row_ok   = (row_q < stop_q) && (row_q < screen_height_q)
			&& (sprite_q || row_q < screen_width_q);
		sts.d_neg    = d_q[17];
		sts.d_ge_h   = d_q[16:0] >= {1'b0, height_q};
		sts.div_last = (cnt_q == '0);
		sts.out_free = !out_valid_q || !result_stall;
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule

[hw/rtl/column_texture_sampler_top.sv]
// Column texture sampler top level: handshake ports, sequencer, datapath and checks.
//
// A start transaction latches one screen column; the block then requests one texel per row and
// turns each returned texel into a pixel write, ending the column with a done result. A fetch
// request follows the start or texel transaction causing it through the check, multiply, divide
// and offset states (clamped rows skip the divide state); the shift-subtract divider yields one
// texture-row bit per cycle, and the pixel state emits a pixel write first. Items are handled
// one at a time: item_stall is low only while the sequencer is idle, and a result waiting in the
// output register does not hold up the next input. In sprite mode, texels of 0 or all ones give
// no pixel write. Configuration writes are always taken and must only be issued while idle.
module column_texture_sampler_top #(
	parameter int TEX_SIZE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  cts_pkg::cts_in_t  item_data,
	output logic              result_valid,
	input  logic              result_stall,
	output cts_pkg::cts_out_t result_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [12:0]       cfg_data
);
	import cts_pkg::*;

	cts_cmd_t   cmd;
	cts_sts_t   sts;
	cts_state_t state;
	logic       item_accept;

	assign cfg_ready   = 1'b1;
	assign item_accept = item_valid && !item_stall;

	cts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_accept (item_accept),
		.sts         (sts),
		.item_stall  (item_stall),
		.cmd         (cmd),
		.state       (state)
	);

	cts_dp #(
		.TEX_SIZE (TEX_SIZE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_data    (item_data),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.result_stall (result_stall),
		.sts          (sts),
		.result_valid (result_valid),
		.result_data  (result_data)
	);

	// a done transaction ends the column
	a_done_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EMIT_DONE) |=> !sts.busy)
		else $error("busy still set after column done");

	// fetch requests always close the work of their input, pixel writes never do
	a_fetch_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.kind == KIND_FETCH) |-> result_data.last)
		else $error("fetch request without last");

	a_pixel_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.kind == KIND_PIXEL) |-> !result_data.last)
		else $error("pixel write marked last");

	// a texel arriving with no column open is dropped without work
	a_idle_texel_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(item_accept && item_data.op == OP_TEXEL && !sts.busy) |=> (state == ST_IDLE))
		else $error("texel while idle started work");

	// no new result is loaded while the register still holds an untaken one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> (cmd.emit == EMIT_NONE))
		else $error("result overwritten while stalled");

endmodule

[tb/column_texture_sampler_top_tb.sv]
// Self-checking testbench for the column texture sampler: directed columns, pressure and random.
module column_texture_sampler_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cts_pkg::*;

	localparam int TEX_SIZE     = 64;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = 40;
	localparam int RANDOM_ITEMS = 375;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_stall;
	cts_in_t  item_data = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	cts_out_t result_data;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic [1:0]  cfg_index = CFG_SCREEN_WIDTH;
	logic [12:0] cfg_data = '0;

	column_texture_sampler_top #(.TEX_SIZE(TEX_SIZE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data(item_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the sampler: registers and the latched column
	logic [11:0] scr_w = RST_SCREEN_WIDTH;
	logic [11:0] scr_h = RST_SCREEN_HEIGHT;
	logic [12:0] line_b = RST_LINE_BYTES;
	logic [3:0]  bpp = RST_BYTES_PER_PIXEL;
	bit          col_busy;
	logic [11:0] col_row, col_stop, col_screen_x;
	logic [15:0] col_height = 16'd1;
	logic [5:0]  col_tex_x;
	bit          col_sprite;
	logic [2:0]  col_texture;

	cts_out_t draw_results_q[$];
	int       errors;
	int       items_taken;
	int       cycle_count;
	bit       steady_flow;
	int       result_hold_req;

	function automatic bit row_drawable(logic [11:0] r);
		if (r >= col_stop || r >= scr_h)
			return 1'b0;
		if (!col_sprite && r >= scr_w)
			return 1'b0;
		return 1'b1;
	endfunction

	// Exact floor of the texture row, clamped, then wrapped to the offset width
	function automatic logic [17:0] texel_fetch_offset(logic [11:0] r);
		longint h, d, num, q;
		logic [63:0] off;
		h = longint'(col_height);
		d = longint'(r) + h / 2 - longint'(scr_h) / 2;
		num = d * TEX_SIZE;
		if (num >= 0)
			q = num / h;
		else
			q = -((-num + h - 1) / h);
		if (q < 0)
			q = 0;
		if (q > TEX_SIZE - 1)
			q = TEX_SIZE - 1;
		off = q * longint'(line_b) + longint'(col_tex_x) * longint'(bpp);
		return off[17:0];
	endfunction

	function automatic void push_result(logic [1:0] kind, logic [2:0] tex, logic [17:0] off,
			logic [11:0] px, logic [11:0] py, logic [31:0] color, logic last);
		cts_out_t r;
		r = '0;
		r.kind = kind;
		r.fetch_texture = tex;
		r.fetch_offset = off;
		r.pixel_x = px;
		r.pixel_y = py;
		r.color = color;
		r.last = last;
		draw_results_q.push_back(r);
	endfunction

	function automatic void fetch_or_finish();
		if (row_drawable(col_row)) begin
			push_result(KIND_FETCH, col_texture, texel_fetch_offset(col_row), '0, '0, '0, 1'b1);
		end else begin
			col_busy = 1'b0;
			push_result(KIND_DONE, '0, '0, '0, '0, '0, 1'b1);
		end
	endfunction

	// Returns 0 when the block ignores the transaction
	function automatic bit advance_column(cts_in_t it);
		if (it.op == OP_START) begin
			col_row = it.start_row;
			col_stop = it.bottom_row;
			col_height = (it.column_height == 16'd0) ? 16'd1 : it.column_height;
			col_tex_x = it.tex_x;
			col_screen_x = it.screen_x;
			col_sprite = it.sprite_mode;
			col_texture = it.texture_id;
			col_busy = 1'b1;
			fetch_or_finish();
			return 1'b1;
		end
		if (!col_busy)
			return 1'b0;
		if (!(col_sprite && (it.texel == '0 || it.texel == TEXEL_WHITE)))
			push_result(KIND_PIXEL, '0, '0, col_screen_x, col_row, it.texel, 1'b0);
		col_row = col_row + 12'd1;
		fetch_or_finish();
		return 1'b1;
	endfunction

	function automatic void apply_reg(logic [1:0] idx, logic [12:0] v);
		case (idx)
			CFG_SCREEN_WIDTH: begin
				scr_w = v[11:0];
			end
			CFG_SCREEN_HEIGHT: begin
				scr_h = v[11:0];
			end
			CFG_LINE_BYTES: begin
				line_b = v;
			end
			CFG_BYTES_PER_PIXEL: begin
				bpp = v[3:0];
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		cts_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (draw_results_q.size() == 0) begin
				$error("unexpected result transaction: kind %0d", result_data.kind);
				errors++;
			end else begin
				want = draw_results_q.pop_front();
				check_field("kind", 32'(want.kind), 32'(result_data.kind));
				check_field("fetch_texture", 32'(want.fetch_texture),
					32'(result_data.fetch_texture));
				check_field("fetch_offset", 32'(want.fetch_offset),
					32'(result_data.fetch_offset));
				check_field("pixel_x", 32'(want.pixel_x), 32'(result_data.pixel_x));
				check_field("pixel_y", 32'(want.pixel_y), 32'(result_data.pixel_y));
				check_field("color", want.color, result_data.color);
				check_field("last", 32'(want.last), 32'(result_data.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver pacing: a random stall before each result, or a long hold on request
	initial begin
		int n;
		forever begin
			if (result_hold_req > 0) begin
				n = result_hold_req;
				result_hold_req = 0;
			end else begin
				n = steady_flow ? 0 : $urandom_range(0, 7);
			end
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (!(result_valid && !result_stall));
		end
	end

	// Valid stays high on return; the next call or stop_items decides what follows
	task automatic send_item(cts_in_t it);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= it;
		do
			@(posedge clk);
		while (item_stall);
		if (advance_column(it))
			items_taken++;
	endtask

	task automatic stop_items();
		item_valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		stop_items();
		while (draw_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_config(logic [11:0] w, logic [11:0] h, logic [12:0] lb, logic [3:0] bp);
		logic [1:0]  order[4];
		logic [12:0] vals[4];
		wait_results_drained();
		// a stray texel gives no result, so let any work in flight finish
		repeat (SETTLE_TICKS) @(posedge clk);
		order = '{CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT, CFG_LINE_BYTES, CFG_BYTES_PER_PIXEL};
		vals[CFG_SCREEN_WIDTH] = {1'b0, w};
		vals[CFG_SCREEN_HEIGHT] = {1'b0, h};
		vals[CFG_LINE_BYTES] = lb;
		vals[CFG_BYTES_PER_PIXEL] = {9'd0, bp};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[order[i]];
			do
				@(posedge clk);
			while (!cfg_ready);
			apply_reg(order[i], vals[order[i]]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic cts_in_t start_item(logic [11:0] first, logic [11:0] bottom,
			logic [15:0] height, logic [5:0] tx, logic [11:0] sx, logic spr, logic [2:0] tex);
		cts_in_t it;
		it = '0;
		it.op = OP_START;
		it.start_row = first;
		it.bottom_row = bottom;
		it.column_height = height;
		it.tex_x = tx;
		it.screen_x = sx;
		it.sprite_mode = spr;
		it.texture_id = tex;
		return it;
	endfunction

	// Texel transaction; the unused fields carry noise the block must ignore
	function automatic cts_in_t texel_item(logic [31:0] value);
		cts_in_t it;
		it = '0;
		it.op = OP_TEXEL;
		it.start_row = 12'($urandom_range(0, 4095));
		it.bottom_row = 12'($urandom_range(0, 4095));
		it.column_height = 16'($urandom_range(0, 65535));
		it.tex_x = 6'($urandom_range(0, 63));
		it.screen_x = 12'($urandom_range(0, 4095));
		it.sprite_mode = 1'($urandom_range(0, 1));
		it.texture_id = 3'($urandom_range(0, 7));
		it.texel = value;
		return it;
	endfunction

	function automatic logic [31:0] random_texel(bit spr);
		if (spr) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return TEXEL_WHITE;
				default: return $urandom;
			endcase
		end
		return $urandom;
	endfunction

	task automatic finish_column();
		while (col_busy)
			send_item(texel_item(random_texel(col_sprite)));
	endtask

	task automatic test_reset_values();
		send_item(texel_item(32'h1234_5678));   // idle texel, ignored
		send_item(start_item(12'd238, 12'd241, 16'd200, 6'd63, 12'd4095, 1'b0, 3'd0));
		send_item(texel_item(32'h0000_0000));
		send_item(texel_item(TEXEL_WHITE));
		send_item(texel_item(32'hA5A5_A5A5));
		send_item(start_item(12'd300, 12'd303, 16'd65535, 6'd17, 12'd99, 1'b1, 3'd4));
		send_item(texel_item(32'h0000_0000));
		send_item(texel_item(TEXEL_WHITE));
		send_item(texel_item(32'h00FF_00FF));
		send_item(start_item(12'd10, 12'd10, 16'd50, 6'd1, 12'd1, 1'b0, 3'd1));
		send_item(start_item(12'd480, 12'd900, 16'd50, 6'd1, 12'd1, 1'b1, 3'd2));
		send_item(start_item(12'd479, 12'd4095, 16'd50, 6'd2, 12'd2, 1'b1, 3'd3));
		send_item(texel_item(32'hDEAD_BEEF));
		// zero height behaves as one; rows far above centre clamp to texture row 0
		send_item(start_item(12'd0, 12'd2, 16'd0, 6'd5, 12'd0, 1'b0, 3'd7));
		finish_column();
		// rows far below centre of a short column clamp to the last texture row
		send_item(start_item(12'd470, 12'd472, 16'd4, 6'd9, 12'd7, 1'b0, 3'd6));
		finish_column();
		// restart while a column is still running
		send_item(start_item(12'd100, 12'd110, 16'd300, 6'd3, 12'd3, 1'b0, 3'd2));
		send_item(texel_item(32'h0BAD_F00D));
		send_item(start_item(12'd100, 12'd101, 16'd1000, 6'd0, 12'd0, 1'b0, 3'd5));
		finish_column();
	endtask

	task automatic test_register_extremes();
		set_config(12'd4095, 12'd4095, 13'd8191, 4'd15);
		send_item(start_item(12'd4093, 12'd4095, 16'd65535, 6'd63, 12'd4095, 1'b0, 3'd6));
		finish_column();
		send_item(start_item(12'd2047, 12'd2050, 16'd3, 6'd63, 12'd2048, 1'b1, 3'd4));
		finish_column();
		// narrow screen: wall rows stop at the width, sprite rows do not
		set_config(12'd1, 12'd4095, 13'd1, 4'd1);
		send_item(start_item(12'd0, 12'd3, 16'd64, 6'd10, 12'd5, 1'b0, 3'd0));
		finish_column();
		send_item(start_item(12'd0, 12'd3, 16'd64, 6'd10, 12'd5, 1'b1, 3'd4));
		finish_column();
		set_config(12'd1, 12'd1, 13'd1, 4'd1);
		send_item(start_item(12'd0, 12'd5, 16'd1, 6'd63, 12'd1, 1'b1, 3'd4));
		finish_column();
		set_config(12'd0, 12'd0, 13'd0, 4'd0);
		send_item(start_item(12'd0, 12'd5, 16'd8, 6'd63, 12'd1, 1'b1, 3'd4));
		finish_column();
		set_config(RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_LINE_BYTES, RST_BYTES_PER_PIXEL);
	endtask

	task automatic test_result_backpressure();
		steady_flow = 1'b1;
		result_hold_req = 150;
		send_item(start_item(12'd100, 12'd130, 16'd240, 6'd21, 12'd321, 1'b0, 3'd1));
		finish_column();
		steady_flow = 1'b0;
	endtask

	task automatic test_sender_pause();
		send_item(start_item(12'd200, 12'd206, 16'd90, 6'd44, 12'd600, 1'b1, 3'd4));
		while (col_busy) begin
			send_item(texel_item(random_texel(1'b1)));
			if ($urandom_range(0, 1) == 0)
				wait_results_drained();
		end
	endtask

	task automatic random_column();
		cts_in_t     it;
		int          len;
		logic [11:0] first;
		it = '0;
		if ($urandom_range(0, 3) != 0 && scr_h > 0)
			first = 12'($urandom_range(0, scr_h - 1));
		else
			first = 12'($urandom_range(0, 4095));
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 6);
		it.op = OP_START;
		it.start_row = first;
		it.bottom_row = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
			: first + 12'(len);
		case ($urandom_range(0, 7))
			0: it.column_height = '0;
			1, 2: it.column_height = 16'($urandom_range(0, 65535));
			default: it.column_height = 16'($urandom_range(1, 512));
		endcase
		it.tex_x = 6'($urandom_range(0, 63));
		it.screen_x = 12'($urandom_range(0, 4095));
		it.sprite_mode = 1'($urandom_range(0, 1));
		it.texture_id = 3'($urandom_range(0, 7));
		it.texel = $urandom;
		steady_flow = ($urandom_range(0, 5) == 0);
		send_item(it);
		while (col_busy) begin
			if ($urandom_range(0, 29) == 0)
				break;   // leave the column for the next start to abandon
			send_item(texel_item(random_texel(col_sprite)));
		end
		if ($urandom_range(0, 9) == 0)
			send_item(texel_item($urandom));
	endtask

	function automatic logic [12:0] pick_reg(int top, int rst);
		case ($urandom_range(0, 4))
			0: return 13'(rst);
			1: return 13'($urandom_range(0, top));
			2: return 13'($urandom_range(1, 64));
			3: return 13'(top);
			default: return 13'($urandom_range(rst / 2, rst * 2));
		endcase
	endfunction

	task automatic test_random_columns();
		int target;
		int phases;
		phases = 6;
		target = items_taken + RANDOM_ITEMS;
		for (int p = 0; p < phases; p++) begin
			if (p > 0)
				set_config(12'(pick_reg(4095, int'(RST_SCREEN_WIDTH))),
					12'(pick_reg(4095, int'(RST_SCREEN_HEIGHT))),
					pick_reg(8191, int'(RST_LINE_BYTES)),
					4'(pick_reg(15, int'(RST_BYTES_PER_PIXEL))));
			while (items_taken < target - (phases - 1 - p) * RANDOM_ITEMS / phases)
				random_column();
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_register_extremes();
		test_result_backpressure();
		test_sender_pause();
		test_random_columns();
		wait_results_drained();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
